FILE: design/tdm_pkg.sv
package tdm_pkg;

   localparam int PHASE_W     = 26;
   localparam int FRAC_W      = 16;
   localparam int INDEX_W     = PHASE_W - FRAC_W;
   localparam int ROM_DEPTH   = 1 << INDEX_W;
   localparam int TABLE_SIZE  = 1024;
   localparam int SINE_W      = 16;
   localparam int VOL_W       = 12;
   localparam int DAC_W       = 12;
   localparam int SCALE_SHIFT = 17;
   localparam int PROD_W      = SINE_W + 1 + VOL_W + 1;
   localparam int CSR_IDX_W   = 1;

   localparam logic [DAC_W-1:0]     DAC_OFFSET  = 12'd2048;
   localparam logic [PHASE_W:0]     WRAP_LIMIT  = (PHASE_W + 1)'(TABLE_SIZE) << FRAC_W;
   localparam logic [63:0]          HALF_PI_Q62 = 64'h6487ED5110B4611A;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_A  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_B  = 1'b1;

   typedef struct packed {
      logic               wr;
      logic [PHASE_W-1:0] value;
   } step_wr_type;

   typedef logic signed [SINE_W-1:0] sine_type;
   typedef sine_type sine_table_type [ROM_DEPTH];

   // (a * b) >> 62, full-width product
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // truncated 32767 * sin(pi/2 * a / TABLE_SIZE); Taylor series in Q62
   function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned a);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] res;
      if (a == 0) begin
         return '0;
      end
      if (a >= TABLE_SIZE) begin
         return 16'd32767;
      end
      q = HALF_PI_Q62 / 64'(TABLE_SIZE);
      r = HALF_PI_Q62 % 64'(TABLE_SIZE);
      x = q * 64'(a) + (r * 64'(a)) / 64'(TABLE_SIZE);
      x2 = mul_q62(x, x);
      t = x;
      s = x;
      t = mul_q62(t, x2) / 64'd6;   s = s - t;
      t = mul_q62(t, x2) / 64'd20;  s = s + t;
      t = mul_q62(t, x2) / 64'd42;  s = s - t;
      t = mul_q62(t, x2) / 64'd72;  s = s + t;
      t = mul_q62(t, x2) / 64'd110; s = s - t;
      t = mul_q62(t, x2) / 64'd156; s = s + t;
      t = mul_q62(t, x2) / 64'd210; s = s - t;
      t = mul_q62(t, x2) / 64'd272; s = s + t;
      t = mul_q62(t, x2) / 64'd342; s = s - t;
      t = mul_q62(t, x2) / 64'd420; s = s + t;
      t = mul_q62(t, x2) / 64'd506; s = s - t;
      t = mul_q62(t, x2) / 64'd600; s = s + t;
      t = mul_q62(t, x2) / 64'd702; s = s - t;
      t = mul_q62(t, x2) / 64'd812; s = s + t;
      res = mul_q62(s, 64'd32767);
      return res[SINE_W-1:0];
   endfunction

   function automatic sine_type table_entry(input int unsigned i);
      int unsigned four;
      int unsigned quad;
      int unsigned rem;
      int unsigned a;
      sine_type    m;
      four = 4 * i;
      quad = four / TABLE_SIZE;
      rem  = four % TABLE_SIZE;
      a    = quad[0] ? TABLE_SIZE - rem : rem;
      m    = sine_type'(quarter_sine(a));
      return quad[1] ? -m : m;
   endfunction

   // indexed by the integer part of the phase; entries repeat modulo TABLE_SIZE
   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      for (int j = 0; j < ROM_DEPTH; j++) begin
         tab[j] = table_entry(j % TABLE_SIZE);
      end
      return tab;
   endfunction

endpackage

FILE: design/tdm_phase_acc.sv
module tdm_phase_acc (
   input  logic                           clock,
   input  logic                           reset,
   input  tdm_pkg::step_wr_type           step_wr,
   input  logic                           advance,
   output logic [tdm_pkg::INDEX_W-1:0]    rom_index
);
   import tdm_pkg::*;

   logic [PHASE_W-1:0] step_ff;
   logic [PHASE_W-1:0] step_in;
   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [PHASE_W:0]   sum;
   logic [PHASE_W:0]   wrapped;

   always_comb begin
      sum     = {1'b0, phase_ff} + {1'b0, step_ff};
      wrapped = (sum >= WRAP_LIMIT) ? sum - WRAP_LIMIT : sum;
      step_in = step_wr.wr ? step_wr.value : step_ff;
      if (step_wr.wr && step_wr.value == '0) begin
         phase_in = '0;
      end else if (advance) begin
         phase_in = wrapped[PHASE_W-1:0];
      end else begin
         phase_in = phase_ff;
      end
   end

   assign rom_index = phase_in[PHASE_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         phase_ff <= '0;
      end else begin
         step_ff  <= step_in;
         phase_ff <= phase_in;
      end
   end

   a_zero_step_clears: assert property (@(posedge clock) disable iff (reset)
      step_wr.wr && step_wr.value == '0 |=> phase_ff == '0)
      else $error("zero step did not clear phase");

   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      !advance && !step_wr.wr |=> $stable(phase_ff))
      else $error("phase moved without a word");

   a_index_matches: assert property (@(posedge clock) disable iff (reset)
      advance && !step_wr.wr |=> phase_ff[PHASE_W-1:FRAC_W] == $past(rom_index))
      else $error("rom index out of step with phase");

endmodule

FILE: design/tdm_sine_rom.sv
module tdm_sine_rom (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [tdm_pkg::INDEX_W-1:0]    index_a,
   input  logic [tdm_pkg::INDEX_W-1:0]    index_b,
   output tdm_pkg::sine_type              sine_a,
   output tdm_pkg::sine_type              sine_b
);
   import tdm_pkg::*;

   localparam sine_table_type SineTable = build_sine_table();

   sine_type sine_a_ff;
   sine_type sine_b_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         sine_a_ff <= SineTable[index_a];
         sine_b_ff <= SineTable[index_b];
      end
   end

   assign sine_a = sine_a_ff;
   assign sine_b = sine_b_ff;

endmodule

FILE: design/tdm_scale.sv
module tdm_scale (
   input  logic                           clock,
   input  logic                           enable,
   input  tdm_pkg::sine_type              sine_a,
   input  tdm_pkg::sine_type              sine_b,
   input  logic [tdm_pkg::VOL_W-1:0]      volume,
   output logic [tdm_pkg::DAC_W-1:0]      dac_code
);
   import tdm_pkg::*;

   logic signed [SINE_W:0]   mix;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] shifted;
   logic [DAC_W-1:0]         dac_code_ff;
   logic [DAC_W-1:0]         dac_code_in;

   always_comb begin
      mix         = (SINE_W + 1)'(sine_a) + (SINE_W + 1)'(sine_b);
      prod        = PROD_W'(mix) * PROD_W'($signed({1'b0, volume}));
      shifted     = prod >>> SCALE_SHIFT;
      dac_code_in = shifted[DAC_W-1:0] + DAC_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dac_code_ff <= dac_code_in;
      end
   end

   assign dac_code = dac_code_ff;

endmodule

FILE: design/two_tone_dds_mixer.sv
// Pipeline: an accepted req word passes the registered sine ROM read, then the
// registered multiply stage, to its rsp word. Throughput: one word per cycle while
// rsp_tready is high (back-pressure stalls it), set by those two registered stages.
// Reset (synchronous): clears both phases, both steps and all valid flags;
// the sine table is fixed and needs no clearing.
module two_tone_dds_mixer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // [11:0] volume
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // [11:0] dac_code
   input  logic                              csr_wen,
   input  logic [tdm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tdm_pkg::PHASE_W-1:0]       csr_wdata
);
   import tdm_pkg::*;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [VOL_W-1:0]   volume_ff;
   logic               out_en;
   logic               s1_en;
   logic               accept;
   step_wr_type        step_wr_a;
   step_wr_type        step_wr_b;
   logic [INDEX_W-1:0] index_a;
   logic [INDEX_W-1:0] index_b;
   sine_type           sine_a;
   sine_type           sine_b;
   logic [DAC_W-1:0]   dac_code;

   always_comb begin
      out_en          = !rsp_valid_ff || rsp_tready;
      s1_en           = !s1_valid_ff || out_en;
      accept          = req_tvalid && s1_en;
      s1_valid_in     = s1_en ? req_tvalid : s1_valid_ff;
      rsp_valid_in    = out_en ? s1_valid_ff : rsp_valid_ff;
      step_wr_a.wr    = csr_wen && csr_index == CSR_STEP_A;
      step_wr_a.value = csr_wdata;
      step_wr_b.wr    = csr_wen && csr_index == CSR_STEP_B;
      step_wr_b.value = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         volume_ff <= req_tdata[VOL_W-1:0];
      end
   end

   tdm_phase_acc u_phase_a (
      .clock     (clock),
      .reset     (reset),
      .step_wr   (step_wr_a),
      .advance   (accept),
      .rom_index (index_a)
   );

   tdm_phase_acc u_phase_b (
      .clock     (clock),
      .reset     (reset),
      .step_wr   (step_wr_b),
      .advance   (accept),
      .rom_index (index_b)
   );

   tdm_sine_rom u_rom (
      .clock   (clock),
      .enable  (s1_en),
      .index_a (index_a),
      .index_b (index_b),
      .sine_a  (sine_a),
      .sine_b  (sine_b)
   );

   tdm_scale u_scale (
      .clock    (clock),
      .enable   (out_en),
      .sine_a   (sine_a),
      .sine_b   (sine_b),
      .volume   (volume_ff),
      .dac_code (dac_code)
   );

   assign req_tready = s1_en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - DAC_W)'(0), dac_code};

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word lost before stage 1");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("rsp word without a stage 1 word");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("req taken with pipeline full");

endmodule

FILE: dv/tb_two_tone_dds_mixer.sv
`timescale 1ns / 100ps

module tb_two_tone_dds_mixer;

   import tdm_pkg::*;

   typedef enum logic [1:0] {
      CFG_NONE,
      CFG_RESTART,
      CFG_A_ONLY,
      CFG_B_ONLY
   } cfg_action_type;

   typedef struct packed {
      cfg_action_type     action;
      logic [PHASE_W-1:0] step_a;
      logic [PHASE_W-1:0] step_b;
      logic [VOL_W-1:0]   volume;
      logic               typed;
      logic [DAC_W-1:0]   code;
   } stim_row_type;

   localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(TABLE_SIZE / 4) << FRAC_W;
   localparam logic [PHASE_W-1:0] HALF_TURN    = PHASE_W'(TABLE_SIZE / 2) << FRAC_W;
   localparam logic [PHASE_W-1:0] THREE_QUARTER = PHASE_W'(3 * TABLE_SIZE / 4) << FRAC_W;
   localparam logic [PHASE_W-1:0] STEP_MAX     = {PHASE_W{1'b1}};
   localparam logic [PHASE_W:0]   PHASE_TURN   = (PHASE_W + 1)'(TABLE_SIZE) << FRAC_W;
   localparam int                 NUM_DIRECTED = 20;
   localparam int                 NUM_PHASES   = 12;
   localparam int                 PHASE_ITEMS  = 128;
   localparam int                 HOLD_CYCLES  = 300;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [15:0]          req_tdata;   // [11:0] volume
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;   // [11:0] dac_code
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PHASE_W-1:0]   csr_wdata;

   logic                 typed_pending;
   logic [DAC_W-1:0]     typed_code;
   logic [DAC_W-1:0]     dac_expect_q [$];
   int                   mismatches;
   bit                   steady;
   bit                   hold_off;

   int                   sine_lut [TABLE_SIZE];
   logic [PHASE_W-1:0]   tone_a_phase;
   logic [PHASE_W-1:0]   tone_b_phase;
   logic [PHASE_W-1:0]   tone_a_step;
   logic [PHASE_W-1:0]   tone_b_step;

   stim_row_type         directed_rows [NUM_DIRECTED];

   two_tone_dds_mixer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------- sine table
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return 64'(p >> 62);
   endfunction

   function automatic int quarter_wave(input int unsigned a);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      if (a == 0) return 0;
      if (a >= TABLE_SIZE) return 32767;
      x = (HALF_PI_Q62 / 64'(TABLE_SIZE)) * 64'(a)
          + ((HALF_PI_Q62 % 64'(TABLE_SIZE)) * 64'(a)) / 64'(TABLE_SIZE);
      x2 = q62_mul(x, x);
      term = x;
      acc = x;
      for (int unsigned k = 1; k < 40 && term != 0; k++) begin
         term = q62_mul(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
         if (k % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      return int'(q62_mul(acc, 64'd32767));
   endfunction

   function automatic int sine_at(input int unsigned i);
      int unsigned quad;
      int unsigned rem;
      int          mag;
      quad = (4 * i) / TABLE_SIZE;
      rem  = (4 * i) % TABLE_SIZE;
      mag  = quarter_wave((quad % 2 == 1) ? TABLE_SIZE - rem : rem);
      return ((quad / 2) % 2 == 1) ? -mag : mag;
   endfunction

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) sine_lut[i] = sine_at(i);
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [PHASE_W-1:0] wrap_phase(input logic [PHASE_W-1:0] ph,
                                                     input logic [PHASE_W-1:0] st);
      logic [PHASE_W:0] p;
      p = {1'b0, ph} + {1'b0, st};
      if (p >= PHASE_TURN) p = p - PHASE_TURN;
      return p[PHASE_W-1:0];
   endfunction

   function automatic logic [DAC_W-1:0] next_dac_code(input logic [VOL_W-1:0] vol);
      int ia;
      int ib;
      int mix;
      tone_a_phase = wrap_phase(tone_a_phase, tone_a_step);
      tone_b_phase = wrap_phase(tone_b_phase, tone_b_step);
      ia  = int'(tone_a_phase >> FRAC_W) % TABLE_SIZE;
      ib  = int'(tone_b_phase >> FRAC_W) % TABLE_SIZE;
      mix = (sine_lut[ia] + sine_lut[ib]) * int'(vol);
      return DAC_W'((mix >>> SCALE_SHIFT) + 2048);
   endfunction

   task automatic set_tone_step(input logic [CSR_IDX_W-1:0] idx,
                                input logic [PHASE_W-1:0] v);
      if (idx == CSR_STEP_A) begin
         tone_a_step = v;
         if (v == 0) tone_a_phase = '0;
      end else if (idx == CSR_STEP_B) begin
         tone_b_step = v;
         if (v == 0) tone_b_phase = '0;
      end
   endtask

   // ---------------------------------------------------------------- monitors
   always @(posedge clock) begin : req_watch
      logic [DAC_W-1:0] predicted;
      if (!reset && req_tvalid && req_tready) begin
         predicted = next_dac_code(req_tdata[VOL_W-1:0]);
         dac_expect_q.push_back(typed_pending ? typed_code : predicted);
      end
   end

   always @(posedge clock) begin : rsp_watch
      logic [DAC_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (dac_expect_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual dac_code %0d",
                     $time, rsp_tdata[DAC_W-1:0]);
            mismatches++;
         end else begin
            want = dac_expect_q.pop_front();
            if (rsp_tdata[DAC_W-1:0] !== want) begin
               $display("%0t: dac_code mismatch, expected %0d, actual %0d",
                        $time, want, rsp_tdata[DAC_W-1:0]);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- idling
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : rsp_side
      int idle_left;
      idle_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else if (idle_left > 0) begin
            rsp_tready <= 1'b0;
            idle_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) idle_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------- sender
   task automatic offer_volume(input logic [VOL_W-1:0] vol, input logic typed,
                               input logic [DAC_W-1:0] code);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= 16'(vol);
      typed_pending <= typed;
      typed_code    <= code;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (dac_expect_q.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PHASE_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      set_tone_step(idx, v);
      @(posedge clock);
   endtask

   task automatic apply_config(input cfg_action_type action, input logic [PHASE_W-1:0] sa,
                               input logic [PHASE_W-1:0] sb);
      case (action)
         CFG_RESTART: begin
            write_reg(CSR_STEP_A, '0);
            write_reg(CSR_STEP_B, '0);
            write_reg(CSR_STEP_A, sa);
            write_reg(CSR_STEP_B, sb);
         end
         CFG_A_ONLY: write_reg(CSR_STEP_A, sa);
         CFG_B_ONLY: write_reg(CSR_STEP_B, sb);
         default: ;
      endcase
      csr_wen <= 1'b0;
   endtask

   function automatic logic [PHASE_W-1:0] pick_step();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return STEP_MAX;
         2: return PHASE_W'($urandom_range(1, 16'hFFFF));
         3: return PHASE_W'($urandom_range(0, TABLE_SIZE - 1)) << FRAC_W;
         4: return STEP_MAX - PHASE_W'($urandom_range(0, 16'hFFFF));
         default: return PHASE_W'($urandom_range(0, (1 << PHASE_W) - 1));
      endcase
   endfunction

   function automatic logic [VOL_W-1:0] pick_volume();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return {VOL_W{1'b1}};
         default: return VOL_W'($urandom());
      endcase
   endfunction

   initial begin : stimulus
      cfg_action_type act;
      int             r;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      typed_pending <= 1'b0;
      typed_code    <= '0;
      csr_wen       <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      mismatches    = 0;
      steady        = 1'b0;
      hold_off      = 1'b0;
      tone_a_phase  = '0;
      tone_b_phase  = '0;
      tone_a_step   = '0;
      tone_b_step   = '0;

      directed_rows = '{
         '{CFG_NONE,    '0,            '0,            12'd4095, 1'b1, 12'd2048},
         '{CFG_NONE,    '0,            '0,            12'd0,    1'b1, 12'd2048},
         '{CFG_RESTART, QUARTER_TURN,  QUARTER_TURN,  12'd4095, 1'b1, 12'd4095},
         '{CFG_NONE,    '0,            '0,            12'd4095, 1'b1, 12'd2048},
         '{CFG_NONE,    '0,            '0,            12'd4095, 1'b1, 12'd0},
         '{CFG_NONE,    '0,            '0,            12'd4095, 1'b1, 12'd2048},
         '{CFG_NONE,    '0,            '0,            12'd0,    1'b1, 12'd2048},
         '{CFG_RESTART, THREE_QUARTER, THREE_QUARTER, 12'd4095, 1'b1, 12'd0},
         '{CFG_NONE,    '0,            '0,            12'd4095, 1'b1, 12'd2048},
         '{CFG_RESTART, QUARTER_TURN,  THREE_QUARTER, 12'd4095, 1'b1, 12'd2048},
         '{CFG_RESTART, STEP_MAX,      26'd1,         12'd4095, 1'b0, 12'd0},
         '{CFG_NONE,    '0,            '0,            12'd2048, 1'b0, 12'd0},
         '{CFG_NONE,    '0,            '0,            12'd1,    1'b0, 12'd0},
         '{CFG_A_ONLY,  '0,            '0,            12'd4095, 1'b0, 12'd0},
         '{CFG_NONE,    '0,            '0,            12'd4095, 1'b0, 12'd0},
         '{CFG_RESTART, HALF_TURN,     26'h0001_8000, 12'd2047, 1'b0, 12'd0},
         '{CFG_NONE,    '0,            '0,            12'd2048, 1'b0, 12'd0},
         '{CFG_NONE,    '0,            '0,            12'd4095, 1'b0, 12'd0},
         '{CFG_B_ONLY,  '0,            '0,            12'd3000, 1'b0, 12'd0},
         '{CFG_NONE,    '0,            '0,            12'd1365, 1'b0, 12'd0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].action != CFG_NONE) begin
            wait_idle();
            apply_config(directed_rows[i].action, directed_rows[i].step_a,
                         directed_rows[i].step_b);
         end
         offer_volume(directed_rows[i].volume, directed_rows[i].typed,
                      directed_rows[i].code);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         steady = (ph == 3 || ph == 8);
         r = $urandom_range(0, 9);
         if (r < 5) act = CFG_RESTART;
         else if (r < 7) act = CFG_A_ONLY;
         else if (r < 9) act = CFG_B_ONLY;
         else act = CFG_NONE;
         apply_config(act, pick_step(), pick_step());
         // long back-pressure so the pipeline fills and stalls req
         if (ph == 5 || ph == 10) hold_off = 1'b1;
         repeat (PHASE_ITEMS) offer_volume(pick_volume(), 1'b0, '0);
      end
      steady = 1'b0;

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && dac_expect_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/tdm_pkg.sv
design/tdm_phase_acc.sv
design/tdm_sine_rom.sv
design/tdm_scale.sv
design/two_tone_dds_mixer.sv
dv/tb_two_tone_dds_mixer.sv
